>>> rtl/core/tlps_pkg.sv
// Shared types, codes and default sizes for the two-level page span map.
`default_nettype none

package tlps_pkg;

    localparam int DEF_LOW_INDEX_BITS  = 10;
    localparam int DEF_HIGH_INDEX_BITS = 10;
    localparam int DEF_SPAN_ID_BITS    = 16;
    localparam int DEF_LEAF_POOL_SIZE  = 16;

    localparam int KEY_BITS        = 32;
    localparam int SPAN_FIELD_BITS = 16;
    localparam int LENGTH_BITS     = 32;

    // Commands waiting between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_LOOKUP_STRICT  = 2'd0,
        OP_LOOKUP_LENIENT = 2'd1,
        OP_STORE          = 2'd2,
        OP_PREALLOC       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_MISSING   = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef struct packed {
        t_op                        operation;
        logic [KEY_BITS-1:0]        page_key;
        logic [SPAN_FIELD_BITS-1:0] span_value;
        logic [LENGTH_BITS-1:0]     range_length;
    } t_in_item;

    typedef struct packed {
        logic [SPAN_FIELD_BITS-1:0] span_found;
        t_status                    status;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_WALK   = 2'd2,
        KIND_REPLY  = 2'd3
    } t_kind;

    // A classified operation as it travels through the queue.
    typedef struct packed {
        t_kind                      kind;
        logic                       strict;
        t_status                    reply;
        logic [KEY_BITS-1:0]        key;
        logic [SPAN_FIELD_BITS-1:0] value;
        logic [KEY_BITS:0]          walk_end;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_CLEAR  = 3'd0,
        BK_IDLE   = 3'd1,
        BK_ROOT   = 3'd2,
        BK_DATA   = 3'd3,
        BK_WALK   = 3'd4,
        BK_FINISH = 3'd5
    } t_back_state;

endpackage

`default_nettype wire

>>> rtl/core/two_level_page_span_map_top.sv
// Two-level page span map: input channel, front classifier, command queue, table engine.
//
// Input channel: i_in_valid / o_in_stall carry one operation (strict lookup, lenient
// lookup, store, preallocate range) per transfer. Output channel: o_out_valid /
// i_out_stall return exactly one result per operation, in order.
// After reset the engine runs a clearing pass over the root table and the leaf pool;
// o_in_stall stays high for its whole length.
// An accepted operation enters a two-entry queue; the engine takes one command at a time.
// The engine's steps per command follow the registered root and leaf memory reads:
// a store reads its root entry, then writes its leaf; a lookup reads its root entry,
// then its leaf (no leaf read when its leaf is missing); an immediate answer (key out
// of range, empty range) goes straight to the result; preallocation walks its range
// leaf by leaf before its result.
// A stalled result stays in the output register; the engine may finish its next command
// up to the point of its result and the queue keeps taking transfers until it is full.
`default_nettype none

module two_level_page_span_map_top #(
    parameter int LOW_INDEX_BITS  = tlps_pkg::DEF_LOW_INDEX_BITS,
    parameter int HIGH_INDEX_BITS = tlps_pkg::DEF_HIGH_INDEX_BITS,
    parameter int SPAN_ID_BITS    = tlps_pkg::DEF_SPAN_ID_BITS,
    parameter int LEAF_POOL_SIZE  = tlps_pkg::DEF_LEAF_POOL_SIZE
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  tlps_pkg::t_in_item i_in_item,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output tlps_pkg::t_out_item      o_out_item
);
    import tlps_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic head_valid;
    logic clearing;

    assign o_in_stall = q_full || clearing;
    assign q_push     = i_in_valid && !o_in_stall;

    tlps_front #(
        .LOW_INDEX_BITS  (LOW_INDEX_BITS),
        .HIGH_INDEX_BITS (HIGH_INDEX_BITS)
    ) u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd)
    );

    tlps_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_cmd        (front_cmd),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (head_valid),
        .o_head       (head_cmd)
    );

    tlps_back #(
        .LOW_INDEX_BITS  (LOW_INDEX_BITS),
        .HIGH_INDEX_BITS (HIGH_INDEX_BITS),
        .SPAN_ID_BITS    (SPAN_ID_BITS),
        .LEAF_POOL_SIZE  (LEAF_POOL_SIZE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_cmd),
        .o_pop        (q_pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire

>>> rtl/core/tlps_front.sv
// Front end: decodes an incoming operation and classifies it into a queue command.
`default_nettype none

module tlps_front #(
    parameter int LOW_INDEX_BITS  = tlps_pkg::DEF_LOW_INDEX_BITS,
    parameter int HIGH_INDEX_BITS = tlps_pkg::DEF_HIGH_INDEX_BITS
) (
    input  wire  tlps_pkg::t_in_item i_item,
    output tlps_pkg::t_cmd           o_cmd
);
    import tlps_pkg::*;

    localparam int TotalBits = LOW_INDEX_BITS + HIGH_INDEX_BITS;

    logic [KEY_BITS:0] key_ext;
    logic              out_of_range;

    assign key_ext      = {1'b0, i_item.page_key};
    assign out_of_range = (key_ext >> TotalBits) != '0;

    always_comb begin
        o_cmd          = '0;
        o_cmd.key      = i_item.page_key;
        o_cmd.value    = i_item.span_value;
        o_cmd.walk_end = key_ext + {1'b0, i_item.range_length};
        o_cmd.strict   = (i_item.operation == OP_LOOKUP_STRICT);
        o_cmd.reply    = ST_OK;
        o_cmd.kind     = KIND_REPLY;
        unique case (i_item.operation) inside
            OP_PREALLOC: begin
                // An empty range is answered at once without touching the tables.
                if (i_item.range_length != '0) begin
                    o_cmd.kind = KIND_WALK;
                end
            end
            OP_STORE: begin
                if (out_of_range) begin
                    o_cmd.reply = ST_RANGE;
                end else begin
                    o_cmd.kind = KIND_STORE;
                end
            end
            OP_LOOKUP_STRICT, OP_LOOKUP_LENIENT: begin
                if (out_of_range) begin
                    o_cmd.reply = ST_RANGE;
                end else begin
                    o_cmd.kind = KIND_LOOKUP;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tlps_queue.sv
// Short command queue that decouples the front end from the table engine.
`default_nettype none

module tlps_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire  tlps_pkg::t_cmd i_cmd,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_head_valid,
    output tlps_pkg::t_cmd       o_head
);
    import tlps_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd            r_slots [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [PtrW:0]   r_count;
    logic [PtrW:0]   n_count;

    assign o_full       = (r_count == (PtrW+1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slots[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (PtrW+1)'(i_push) - (PtrW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tlps_back.sv
// Back end: root table, leaf pool, preallocation walk and the result register.
`default_nettype none

module tlps_back #(
    parameter int LOW_INDEX_BITS  = tlps_pkg::DEF_LOW_INDEX_BITS,
    parameter int HIGH_INDEX_BITS = tlps_pkg::DEF_HIGH_INDEX_BITS,
    parameter int SPAN_ID_BITS    = tlps_pkg::DEF_SPAN_ID_BITS,
    parameter int LEAF_POOL_SIZE  = tlps_pkg::DEF_LEAF_POOL_SIZE
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_head_valid,
    input  wire  tlps_pkg::t_cmd    i_head,
    output logic                    o_pop,
    output logic                    o_clearing,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output tlps_pkg::t_out_item     o_out_item
);
    import tlps_pkg::*;

    localparam int TotalBits = LOW_INDEX_BITS + HIGH_INDEX_BITS;
    localparam int RootDepth = 1 << HIGH_INDEX_BITS;
    localparam int LeafDepth = 1 << LOW_INDEX_BITS;
    localparam int PoolDepth = LEAF_POOL_SIZE * LeafDepth;
    localparam int SlotW     = (LEAF_POOL_SIZE > 1) ? $clog2(LEAF_POOL_SIZE) : 1;
    localparam int UsedW     = $clog2(LEAF_POOL_SIZE + 1);
    localparam int LeafAW    = $clog2(PoolDepth);
    localparam int ClearLen  = (RootDepth > PoolDepth) ? RootDepth : PoolDepth;
    localparam int ClrW      = $clog2(ClearLen);
    localparam int SpanW     = (SPAN_ID_BITS < SPAN_FIELD_BITS) ? SPAN_ID_BITS : SPAN_FIELD_BITS;

    typedef struct packed {
        logic             valid;
        logic [SlotW-1:0] slot;
    } t_root_word;

    typedef struct packed {
        logic             written;
        logic [SpanW-1:0] span;
    } t_leaf_word;

    t_root_word root_mem [RootDepth];
    t_leaf_word leaf_mem [PoolDepth];

    t_back_state r_state;
    t_back_state n_state;
    t_cmd        r_cmd;
    logic [KEY_BITS:0] r_walk_key;
    logic [UsedW-1:0]  r_used;
    logic [ClrW-1:0]   r_clr_cnt;
    t_status           r_fin_status;
    t_root_word        r_root_rd;
    t_leaf_word        r_leaf_rd;
    logic              r_out_vld;
    t_out_item         r_out;

    logic [HIGH_INDEX_BITS-1:0]       cmd_hi;
    logic [LOW_INDEX_BITS-1:0]        cmd_low;
    logic [HIGH_INDEX_BITS-1:0]       head_hi;
    logic [HIGH_INDEX_BITS-1:0]       walk_hi;
    logic [KEY_BITS-LOW_INDEX_BITS:0] walk_upper;
    logic [KEY_BITS:0]                walk_next;
    logic [HIGH_INDEX_BITS-1:0]       walk_next_hi;
    logic                             walk_in_range;
    logic                             walk_at_end;
    logic                             walk_stop;
    logic                             pool_full;
    logic [SlotW+LOW_INDEX_BITS-1:0]  leaf_full_addr;
    logic [LeafAW-1:0]                leaf_addr;
    logic                             clr_in_root;
    logic                             clr_in_pool;
    logic                             clr_last;
    logic                             out_free;

    logic                       root_we;
    logic [HIGH_INDEX_BITS-1:0] root_waddr;
    logic [HIGH_INDEX_BITS-1:0] root_raddr;
    t_root_word                 root_wdata;
    logic                       leaf_we;
    logic [LeafAW-1:0]          leaf_waddr;
    t_leaf_word                 leaf_wdata;
    logic                       walk_adv;
    logic                       used_inc;
    logic                       fin_load;
    t_status                    fin_status;
    logic                       out_load;
    t_out_item                  out_data;

    assign cmd_hi        = r_cmd.key[TotalBits-1:LOW_INDEX_BITS];
    assign cmd_low       = r_cmd.key[LOW_INDEX_BITS-1:0];
    assign head_hi       = i_head.key[TotalBits-1:LOW_INDEX_BITS];
    assign walk_hi       = r_walk_key[TotalBits-1:LOW_INDEX_BITS];
    assign walk_upper    = r_walk_key[KEY_BITS:LOW_INDEX_BITS] + 1'b1;
    assign walk_next     = {walk_upper, {LOW_INDEX_BITS{1'b0}}};
    assign walk_next_hi  = walk_next[TotalBits-1:LOW_INDEX_BITS];
    assign walk_in_range = (r_walk_key >> TotalBits) == '0;
    assign walk_at_end   = !(r_walk_key < r_cmd.walk_end);
    assign pool_full     = (r_used == UsedW'(LEAF_POOL_SIZE));
    // The walk ends at the range end, at the edge of the map, or when a new leaf is needed
    // and the pool has none left.
    assign walk_stop     = walk_at_end || !walk_in_range || (!r_root_rd.valid && pool_full);

    // Leaves are a power of two deep, so the pool position is the slot joined to the low index.
    assign leaf_full_addr = {r_root_rd.slot, cmd_low};
    assign leaf_addr      = leaf_full_addr[LeafAW-1:0];

    assign clr_in_root = ({1'b0, r_clr_cnt} < (ClrW+1)'(RootDepth));
    assign clr_in_pool = ({1'b0, r_clr_cnt} < (ClrW+1)'(PoolDepth));
    assign clr_last    = (r_clr_cnt == ClrW'(ClearLen - 1));
    assign out_free    = !r_out_vld || !i_out_stall;

    assign o_clearing  = (r_state == BK_CLEAR);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (clr_last) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.kind) inside
                        KIND_LOOKUP, KIND_STORE: n_state = BK_ROOT;
                        KIND_WALK:               n_state = BK_WALK;
                        KIND_REPLY:              n_state = BK_FINISH;
                    endcase
                end
            end
            BK_ROOT: begin
                if (r_root_rd.valid && (r_cmd.kind == KIND_LOOKUP)) begin
                    n_state = BK_DATA;
                end else if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            BK_DATA: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            BK_WALK: begin
                if (walk_stop) begin
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        root_we    = 1'b0;
        root_waddr = walk_hi;
        root_raddr = cmd_hi;
        root_wdata = '{valid: 1'b1, slot: r_used[SlotW-1:0]};
        leaf_we    = 1'b0;
        leaf_waddr = leaf_addr;
        leaf_wdata = '{written: 1'b1, span: r_cmd.value[SpanW-1:0]};
        walk_adv   = 1'b0;
        used_inc   = 1'b0;
        fin_load   = 1'b0;
        fin_status = ST_OK;
        out_load   = 1'b0;
        out_data   = '{span_found: '0, status: ST_OK};
        unique case (r_state)
            BK_CLEAR: begin
                root_we    = clr_in_root;
                root_waddr = r_clr_cnt[HIGH_INDEX_BITS-1:0];
                root_wdata = '0;
                leaf_we    = clr_in_pool;
                leaf_waddr = r_clr_cnt[LeafAW-1:0];
                leaf_wdata = '0;
            end
            BK_IDLE: begin
                // Start the root read of the waiting command while it is taken from the queue.
                root_raddr = head_hi;
                o_pop      = i_head_valid;
            end
            BK_ROOT: begin
                if (!r_root_rd.valid) begin
                    out_load = out_free;
                    if ((r_cmd.kind == KIND_STORE) || r_cmd.strict) begin
                        out_data.status = ST_MISSING;
                    end
                end else if (r_cmd.kind == KIND_STORE) begin
                    out_load = out_free;
                    leaf_we  = out_free;
                end
            end
            BK_DATA: begin
                out_load = out_free;
                if (r_leaf_rd.written) begin
                    out_data.span_found = SPAN_FIELD_BITS'(r_leaf_rd.span);
                end
            end
            BK_WALK: begin
                // Fetch the root entry of the next leaf while this one is settled.
                root_raddr = walk_next_hi;
                if (walk_stop) begin
                    fin_load = 1'b1;
                    if (walk_at_end) begin
                        fin_status = ST_OK;
                    end else if (!walk_in_range) begin
                        fin_status = ST_RANGE;
                    end else begin
                        fin_status = ST_EXHAUSTED;
                    end
                end else begin
                    walk_adv = 1'b1;
                    if (!r_root_rd.valid) begin
                        root_we  = 1'b1;
                        used_inc = 1'b1;
                    end
                end
            end
            BK_FINISH: begin
                out_load        = out_free;
                out_data.status = r_fin_status;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_CLEAR;
            r_used    <= '0;
            r_clr_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (used_inc) begin
                r_used <= r_used + 1'b1;
            end
            if (r_state == BK_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd        <= i_head;
            r_walk_key   <= {1'b0, i_head.key};
            r_fin_status <= i_head.reply;
        end else begin
            if (walk_adv) begin
                r_walk_key <= walk_next;
            end
            if (fin_load) begin
                r_fin_status <= fin_status;
            end
        end
        if (out_load) begin
            r_out <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (root_we) begin
            root_mem[root_waddr] <= root_wdata;
        end
        r_root_rd <= root_mem[root_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (leaf_we) begin
            leaf_mem[leaf_waddr] <= leaf_wdata;
        end
        r_leaf_rd <= leaf_mem[leaf_addr];
    end

    a_clear_only_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_CLEAR) |=> (r_state != BK_CLEAR))
        else $error("clearing pass restarted without reset");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UsedW'(LEAF_POOL_SIZE))
        else $error("leaf pool count beyond pool size");

    a_pool_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_used == $past(r_used)) || (r_used == $past(r_used) + 1'b1))
        else $error("leaf pool count moved by more than one leaf");

    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != BK_IDLE) && (r_state != BK_CLEAR))
        else $error("command taken but engine did not start it");

endmodule

`default_nettype wire

>>> test/tb_two_level_page_span_map_top.sv
// Self-checking testbench for the two-level page span map, with its own table predictor.
`default_nettype none

module tb_two_level_page_span_map_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlps_pkg::*;

    localparam int LOW_BITS   = DEF_LOW_INDEX_BITS;
    localparam int HIGH_BITS  = DEF_HIGH_INDEX_BITS;
    localparam int POOL_SIZE  = DEF_LEAF_POOL_SIZE;
    localparam int MAP_BITS   = LOW_BITS + HIGH_BITS;
    localparam int ROOT_SIZE  = 1 << HIGH_BITS;
    localparam int LEAF_SIZE  = 1 << LOW_BITS;
    localparam int SPAN_BITS  = DEF_SPAN_ID_BITS;
    localparam int HOLD_LEN   = 300;
    localparam int TAIL_WAIT  = 8;

    // Mirrors the root table and the leaf pool, and keeps the results still owed by the block.
    class span_map_scoreboard;
        bit                         root_valid [ROOT_SIZE];
        int unsigned                root_slot  [ROOT_SIZE];
        logic [SPAN_FIELD_BITS-1:0] leaf_span  [POOL_SIZE*LEAF_SIZE];
        bit                         span_set   [POOL_SIZE*LEAF_SIZE];
        int unsigned                leaves_used;
        int unsigned                mapped_hi[$];
        t_out_item                  expected_results[$];
        int unsigned                errors;
        int unsigned                result_count;

        function new();
            foreach (root_valid[i]) root_valid[i] = 1'b0;
            foreach (span_set[i]) span_set[i] = 1'b0;
            leaves_used  = 0;
            errors       = 0;
            result_count = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // Walks the page range leaf by leaf, taking fresh leaves from the pool.
        function t_status predict_walk(logic [KEY_BITS-1:0] start, logic [LENGTH_BITS-1:0] len);
            logic [KEY_BITS:0] cur;
            logic [KEY_BITS:0] stop;
            int unsigned       hi;
            int unsigned       slot;
            cur  = {1'b0, start};
            stop = {1'b0, start} + {1'b0, len};
            while (cur < stop) begin
                if ((cur >> MAP_BITS) != 0) return ST_RANGE;
                hi = int'((cur >> LOW_BITS) & (ROOT_SIZE - 1));
                if (!root_valid[hi]) begin
                    if (leaves_used >= POOL_SIZE) return ST_EXHAUSTED;
                    slot = leaves_used;
                    for (int e = 0; e < LEAF_SIZE; e++) span_set[slot*LEAF_SIZE + e] = 1'b0;
                    root_slot[hi]  = slot;
                    root_valid[hi] = 1'b1;
                    leaves_used    = slot + 1;
                    mapped_hi.push_back(hi);
                end
                cur = ((cur >> LOW_BITS) + 1) << LOW_BITS;
            end
            return ST_OK;
        endfunction

        function void note_transfer(t_in_item it);
            t_out_item                  res;
            int unsigned                hi;
            int unsigned                lo;
            int unsigned                pos;
            logic [SPAN_FIELD_BITS-1:0] value;
            res.span_found = '0;
            res.status     = ST_OK;
            value = it.span_value & SPAN_FIELD_BITS'((64'd1 << SPAN_BITS) - 1);
            if (it.operation == OP_PREALLOC) begin
                res.status = predict_walk(it.page_key, it.range_length);
            end else if ((it.page_key >> MAP_BITS) != 0) begin
                res.status = ST_RANGE;
            end else begin
                hi = int'((it.page_key >> LOW_BITS) & (ROOT_SIZE - 1));
                lo = int'(it.page_key & (LEAF_SIZE - 1));
                if (!root_valid[hi]) begin
                    if (it.operation != OP_LOOKUP_LENIENT) res.status = ST_MISSING;
                end else begin
                    pos = root_slot[hi] * LEAF_SIZE + lo;
                    if (it.operation == OP_STORE) begin
                        leaf_span[pos] = value;
                        span_set[pos]  = 1'b1;
                    end else if (span_set[pos]) begin
                        res.span_found = leaf_span[pos];
                    end
                end
            end
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            errors++;
            if (errors <= 100)
                $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                         result_count, what, got, want);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, span", got.span_found, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.span_found !== want.span_found)
                    report_mismatch("span_found", got.span_found, want.span_found);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
            result_count++;
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    span_map_scoreboard sb;

    int          send_idle_pct;
    int          stall_pct;
    bit          hold_req;
    bit          hold_ack;
    int unsigned hold_left;

    two_level_page_span_map_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off once one is requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_left = HOLD_LEN;
            hold_ack  = hold_req;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) sb.check_result(out_item);
    end

    function automatic t_in_item make_item(t_op op, logic [31:0] key, logic [15:0] value,
                                           logic [31:0] len);
        t_in_item it;
        it.operation    = op;
        it.page_key     = key;
        it.span_value   = value;
        it.range_length = len;
        return it;
    endfunction

    // Mostly keys inside leaves that exist, so lookups and stores reach the pool.
    function automatic logic [31:0] pick_key();
        int unsigned pick;
        int unsigned hi;
        int unsigned lo;
        pick = $urandom_range(0, 99);
        if (pick < 70 && sb.mapped_hi.size() != 0) begin
            hi = sb.mapped_hi[$urandom_range(0, sb.mapped_hi.size() - 1)];
            if ($urandom_range(0, 1) == 0) lo = $urandom_range(0, 15);
            else lo = $urandom_range(0, LEAF_SIZE - 1);
            return 32'((hi << LOW_BITS) | lo);
        end else if (pick < 82) begin
            return 32'($urandom_range(0, (1 << MAP_BITS) - 1));
        end else if (pick < 92) begin
            return $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0: return 32'h0;
                1: return 32'((1 << MAP_BITS) - 1);
                2: return 32'(1 << MAP_BITS);
                default: return 32'hFFFF_FFFF;
            endcase
        end
    endfunction

    function automatic t_in_item random_item();
        int unsigned pick;
        t_op         op;
        logic [31:0] len;
        logic [15:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 25) op = OP_LOOKUP_STRICT;
        else if (pick < 50) op = OP_LOOKUP_LENIENT;
        else if (pick < 90) op = OP_STORE;
        else op = OP_PREALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 60) len = $urandom_range(0, 2047);
        else if (pick < 80) len = $urandom_range(0, 16);
        else if (pick < 90) len = '0;
        else len = $urandom;
        value = ($urandom_range(0, 15) == 0) ? 16'h0 : 16'($urandom);
        return make_item(op, pick_key(), value, len);
    endfunction

    // Offers one item after a random gap and holds it until the transfer.
    task send_item(t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        forever begin
            @(posedge i_clk);
            if (!in_stall) break;
        end
        sb.note_transfer(it);
    endtask

    task wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task run_phase(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        for (int n = 0; n < count; n++) send_item(random_item());
        wait_drained();
    endtask

    initial begin
        #4_000_000;
        $display("[two_level_page_span_map_top] ERROR");
        $finish;
    end

    initial begin
        sb            = new();
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        hold_ack      = 1'b0;
        hold_left     = 0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty map, out-of-range keys, fresh leaves, null stores, range ends.
        send_item(make_item(OP_LOOKUP_STRICT,  32'h0000_0000, 16'h0000, 32'h0));
        send_item(make_item(OP_LOOKUP_LENIENT, 32'h0000_03FF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_STORE,          32'h0000_1234, 16'hAAAA, 32'h0));
        send_item(make_item(OP_LOOKUP_STRICT,  32'hFFFF_FFFF, 16'h0000, 32'h0));
        send_item(make_item(OP_STORE,          32'h0010_0000, 16'h5555, 32'h0));
        send_item(make_item(OP_LOOKUP_LENIENT, 32'h8000_0000, 16'h0000, 32'h0));
        send_item(make_item(OP_PREALLOC,       32'h0000_0000, 16'h0000, 32'h0));
        send_item(make_item(OP_PREALLOC,       32'h0000_0000, 16'h0000, 32'h1));
        send_item(make_item(OP_LOOKUP_STRICT,  32'h0000_0000, 16'h0000, 32'h0));
        send_item(make_item(OP_STORE,          32'h0000_0000, 16'hFFFF, 32'h0));
        send_item(make_item(OP_LOOKUP_STRICT,  32'h0000_0000, 16'h0000, 32'h0));
        send_item(make_item(OP_STORE,          32'h0000_03FF, 16'h8001, 32'h0));
        send_item(make_item(OP_LOOKUP_LENIENT, 32'h0000_03FF, 16'h0000, 32'h0));
        send_item(make_item(OP_STORE,          32'h0000_03FF, 16'h0000, 32'h0));
        send_item(make_item(OP_LOOKUP_STRICT,  32'h0000_03FF, 16'h0000, 32'h0));
        send_item(make_item(OP_PREALLOC,       32'h000F_FFFF, 16'h0000, 32'h2));
        send_item(make_item(OP_STORE,          32'h000F_FFFF, 16'h5A5A, 32'h0));
        send_item(make_item(OP_LOOKUP_STRICT,  32'h000F_FFFF, 16'h0000, 32'h0));
        send_item(make_item(OP_PREALLOC,       32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_LOOKUP_STRICT,  32'h0000_0400, 16'h0000, 32'h0));
        send_item(make_item(OP_LOOKUP_LENIENT, 32'h0000_0400, 16'h0000, 32'h0));
        wait_drained();

        run_phase(430, 0, 0);

        // Receiver holds off while the sender keeps offering, so the queue fills up.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = ~hold_req;
        for (int n = 0; n < 20; n++) send_item(random_item());
        wait_drained();

        run_phase(430, 87, 0);
        run_phase(430, 0, 87);
        run_phase(430, 21, 21);

        if (sb.pending() != 0) sb.report_mismatch("results never returned", 0, sb.pending());
        if (sb.errors == 0) begin
            $display("[two_level_page_span_map_top] OK");
        end else begin
            $display("[two_level_page_span_map_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
